/* rtl/core/motor_soft_reversal_with_percent_display_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the motor soft reversal block
// Concurrent checks clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MOTOR_SOFT_REVERSAL_WITH_PERCENT_DISPLAY_MACROS_SVH
`define MOTOR_SOFT_REVERSAL_WITH_PERCENT_DISPLAY_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define MSRPD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("check failed: same-cycle implication");

// Next-cycle implication.
`define MSRPD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed: next-cycle implication");

`else

`define MSRPD_ASSERT_NOW(label, ante, cons)
`define MSRPD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/core/msrpd_pkg.sv */
// ----------------------------------------------------------------------------
// msrpd_pkg
// Shared widths, register codes, reset values and helpers.
// ----------------------------------------------------------------------------
package msrpd_pkg;

	localparam int SAMPLE_BITS     = 12;
	localparam int TICK_COUNT_BITS = 20;
	localparam int CFG_DATA_BITS   = 20;
	localparam int CFG_INDEX_BITS  = 3;
	localparam int PCT_BITS        = 7;
	localparam int SEG_BITS        = 7;
	localparam int DIGIT_BITS      = 3;

	localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE      = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RAMP_INTERVAL = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RAMP_STEP     = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MUX_INTERVAL  = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_COMMON_ANODE  = 3'd4;

	localparam logic [CFG_DATA_BITS-1:0] DEBOUNCE_RESET      = 20'd20000;
	localparam logic [CFG_DATA_BITS-1:0] RAMP_INTERVAL_RESET = 20'd500000;
	localparam logic [SAMPLE_BITS-1:0]   RAMP_STEP_RESET     = SAMPLE_BITS'(409);
	localparam logic [CFG_DATA_BITS-1:0] MUX_INTERVAL_RESET  = 20'd2000;

	typedef logic [TICK_COUNT_BITS-1:0] tick_cnt_t;

	typedef struct packed {
		logic [CFG_DATA_BITS-1:0] mux_interval;
		logic                     common_anode;
	} disp_cfg_t;

	typedef struct packed {
		logic [SEG_BITS-1:0]   segments;
		logic [DIGIT_BITS-1:0] digit_enable;
	} disp_out_t;

	// Saturating tick counter advance.
	function automatic tick_cnt_t sat_inc(input tick_cnt_t v);
		sat_inc = (v == '1) ? v : v + 1'b1;
	endfunction

	// Counter against interval register, both zero-extended.
	function automatic logic tick_due(input tick_cnt_t cnt, input logic [CFG_DATA_BITS-1:0] lim);
		tick_due = (32'(cnt) >= 32'(lim));
	endfunction

	// floor(sample * 100 / (2^SAMPLE_BITS - 1)). Dividing by 2^n - 1 is
	// (x + (x >> n) + 1) >> n, exact for x below 2^(2n).
	function automatic logic [PCT_BITS-1:0] pct_of(input logic [SAMPLE_BITS-1:0] s);
		logic [SAMPLE_BITS+7:0] x;
		logic [SAMPLE_BITS+7:0] t;
		x = (SAMPLE_BITS+8)'(s) * (SAMPLE_BITS+8)'(100);
		t = x + (x >> SAMPLE_BITS) + 1'b1;
		pct_of = PCT_BITS'(t >> SAMPLE_BITS);
	endfunction

endpackage

/* rtl/core/motor_soft_reversal_with_percent_display.sv */
// ----------------------------------------------------------------------------
// motor_soft_reversal_with_percent_display
// Debounced left/right reversal with soft ramp-down and a percent display.
// ----------------------------------------------------------------------------
// Path: an accepted tick request goes into the input register, which feeds the
// state update; the state registers are the result register. Throughput: one
// tick per clock while out_stall does not hold back a waiting result.
// Reset: arst_n clears all control state and loads the register defaults;
// the block takes requests from the first clock after reset is released.
// ----------------------------------------------------------------------------
`include "motor_soft_reversal_with_percent_display_macros.svh"

module motor_soft_reversal_with_percent_display
	import msrpd_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,

	// tick requests
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      left_press,
	input  logic                      right_press,
	input  logic                      sample_valid,
	input  logic [SAMPLE_BITS-1:0]    sample_value,

	// result requests
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [SAMPLE_BITS-1:0]    duty_forward,
	output logic [SAMPLE_BITS-1:0]    duty_reverse,
	output logic                      red_led,
	output logic                      green_led,
	output logic [SEG_BITS-1:0]       segments,
	output logic [DIGIT_BITS-1:0]     digit_enable,

	// configuration writes
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	// configuration registers
	logic [CFG_DATA_BITS-1:0] debounce_q;
	logic [CFG_DATA_BITS-1:0] ramp_interval_q;
	logic [SAMPLE_BITS-1:0]   ramp_step_q;
	logic [CFG_DATA_BITS-1:0] mux_interval_q;
	logic                     common_anode_q;

	// input register
	logic                     valid_s1;
	logic                     lp_s1;
	logic                     rp_s1;
	logic                     sv_s1;
	logic [SAMPLE_BITS-1:0]   sample_s1;
	logic [PCT_BITS-1:0]      pct_s1;

	// controller state
	tick_cnt_t                press_elapsed_q;
	tick_cnt_t                ramp_elapsed_q;
	logic                     pending_left_q;
	logic                     pending_right_q;
	logic                     level_captured_q;
	logic [SAMPLE_BITS-1:0]   ramp_level_q;
	logic [SAMPLE_BITS-1:0]   latest_sample_q;
	logic [PCT_BITS-1:0]      percent_q;
	logic [SAMPLE_BITS-1:0]   fwd_q;
	logic [SAMPLE_BITS-1:0]   rev_q;
	logic                     red_q;
	logic                     green_q;
	logic                     out_valid_q;

	logic                     adv;
	logic                     load_s1;

	// next-state values
	logic                     acc_left;
	logic                     acc_right;
	logic                     pl_n;
	logic                     pr_n;
	logic                     cap_n;
	logic [SAMPLE_BITS-1:0]   latest_n;
	logic [PCT_BITS-1:0]      percent_n;
	logic [SAMPLE_BITS-1:0]   level_cur;
	logic [SAMPLE_BITS-1:0]   level_n;
	logic [SAMPLE_BITS-1:0]   fwd_n;
	logic [SAMPLE_BITS-1:0]   rev_n;
	logic                     red_n;
	logic                     green_n;
	logic                     ramp_restart;
	logic                     ramp_due;

	disp_cfg_t                disp_cfg;
	disp_out_t                disp;

	// ---------------------------------------------------------------------
	// Handshake: the held tick advances whenever the result slot is free or
	// is being taken in this cycle. Refill the input register in the same
	// cycle so a tick enters every clock while the result slot keeps draining.
	// ---------------------------------------------------------------------
	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign load_s1  = !valid_s1 || adv;
	assign in_stall = !load_s1;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q      <= DEBOUNCE_RESET;
			ramp_interval_q <= RAMP_INTERVAL_RESET;
			ramp_step_q     <= RAMP_STEP_RESET;
			mux_interval_q  <= MUX_INTERVAL_RESET;
			common_anode_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DEBOUNCE:      debounce_q      <= cfg_data;
				REG_RAMP_INTERVAL: ramp_interval_q <= cfg_data;
				REG_RAMP_STEP:     ramp_step_q     <= cfg_data[SAMPLE_BITS-1:0];
				REG_MUX_INTERVAL:  mux_interval_q  <= cfg_data;
				REG_COMMON_ANODE:  common_anode_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	// Take the payload with its percent already worked out, so the state
	// update sees only a mux on the sample path.
	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			lp_s1     <= left_press;
			rp_s1     <= right_press;
			sv_s1     <= sample_valid;
			sample_s1 <= sample_value;
			pct_s1    <= pct_of(sample_value);
		end
	end

	// ---------------------------------------------------------------------
	// Tick update, in order: presses (left first), sample, reversal.
	// ---------------------------------------------------------------------
	always_comb begin
		// shared debounce window; a left acceptance restarts it, so right
		// passes on the same tick only with a zero window
		acc_left  = lp_s1 && tick_due(press_elapsed_q, debounce_q);
		acc_right = rp_s1 && (acc_left ? (debounce_q == '0)
		                               : tick_due(press_elapsed_q, debounce_q));
		pl_n = pending_left_q  || acc_left;
		pr_n = pending_right_q || acc_right;

		latest_n  = sv_s1 ? sample_s1 : latest_sample_q;
		percent_n = sv_s1 ? pct_s1    : percent_q;

		cap_n        = level_captured_q;
		level_cur    = level_captured_q ? ramp_level_q : latest_n;
		level_n      = ramp_level_q;
		fwd_n        = fwd_q;
		rev_n        = rev_q;
		red_n        = red_q;
		green_n      = green_q;
		ramp_restart = 1'b0;
		ramp_due     = tick_due(ramp_elapsed_q, ramp_interval_q);

		if (pl_n || pr_n) begin
			// capture the level once per reversal
			cap_n   = 1'b1;
			level_n = level_cur;
			if (ramp_due) begin
				if (level_cur != '0) begin
					// step the opposite channel down, floor at zero
					level_n = (level_cur > ramp_step_q) ? level_cur - ramp_step_q : '0;
					if (pl_n) begin
						rev_n = level_n;
					end else begin
						fwd_n = level_n;
					end
					ramp_restart = 1'b1;
				end else begin
					// opposite channel at rest: drive the chosen one
					if (pl_n) begin
						fwd_n   = latest_n;
						red_n   = 1'b1;
						green_n = 1'b0;
						pl_n    = 1'b0;
					end else begin
						rev_n   = latest_n;
						red_n   = 1'b0;
						green_n = 1'b1;
						pr_n    = 1'b0;
					end
					cap_n = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_elapsed_q  <= '0;
			ramp_elapsed_q   <= '0;
			pending_left_q   <= 1'b0;
			pending_right_q  <= 1'b0;
			level_captured_q <= 1'b0;
			ramp_level_q     <= '0;
			latest_sample_q  <= '0;
			percent_q        <= '0;
			fwd_q            <= '0;
			rev_q            <= '0;
			red_q            <= 1'b0;
			green_q          <= 1'b0;
		end else if (adv) begin
			press_elapsed_q  <= sat_inc((acc_left || acc_right) ? '0 : press_elapsed_q);
			ramp_elapsed_q   <= sat_inc(ramp_restart ? '0 : ramp_elapsed_q);
			pending_left_q   <= pl_n;
			pending_right_q  <= pr_n;
			level_captured_q <= cap_n;
			ramp_level_q     <= level_n;
			latest_sample_q  <= latest_n;
			percent_q        <= percent_n;
			fwd_q            <= fwd_n;
			rev_q            <= rev_n;
			red_q            <= red_n;
			green_q          <= green_n;
		end
	end

	// Hold the result until it is taken; a new one replaces it on advance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// ---------------------------------------------------------------------
	// Display: fed the percent after this tick's sample update.
	// ---------------------------------------------------------------------
	assign disp_cfg.mux_interval = mux_interval_q;
	assign disp_cfg.common_anode = common_anode_q;

	msrpd_display u_display (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (adv),
		.cfg     (disp_cfg),
		.percent (percent_n),
		.disp    (disp)
	);

	assign out_valid    = out_valid_q;
	assign duty_forward = fwd_q;
	assign duty_reverse = rev_q;
	assign red_led      = red_q;
	assign green_led    = green_q;
	assign segments     = disp.segments;
	assign digit_enable = disp.digit_enable;

	// ---------------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------------
	`MSRPD_ASSERT_NOW(a_led_exclusive, 1'b1, $onehot0({red_q, green_q}))
	`MSRPD_ASSERT_NOW(a_digit_onehot, 1'b1, $onehot0(digit_enable))
	`MSRPD_ASSERT_NOW(a_capture_needs_pending, level_captured_q, pending_left_q || pending_right_q)
	`MSRPD_ASSERT_NEXT(a_advance_gives_result, adv, out_valid)

endmodule

/* rtl/core/msrpd_display.sv */
// ----------------------------------------------------------------------------
// msrpd_display
// Three-digit multiplexed 7-segment driver for the 0-100 percent value.
// ----------------------------------------------------------------------------
module msrpd_display
	import msrpd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tick,
	input  disp_cfg_t           cfg,
	input  logic [PCT_BITS-1:0] percent,
	output disp_out_t           disp
);

	typedef enum logic [1:0] {
		PH_UNITS,
		PH_TENS,
		PH_HUNDREDS
	} phase_t;

	tick_cnt_t             mux_elapsed_q;
	phase_t                phase_q;
	logic [SEG_BITS-1:0]   seg_q;
	logic [DIGIT_BITS-1:0] en_q;

	logic                  due;
	logic [PCT_BITS-1:0]   q10;
	logic [3:0]            units;
	logic [3:0]            tens;
	logic [3:0]            hundreds;
	logic [3:0]            digit;
	logic [SEG_BITS-1:0]   seg_raw;
	logic [DIGIT_BITS-1:0] en_next;
	phase_t                phase_next;
	logic [15:0]           prod10;

	function automatic logic [SEG_BITS-1:0] seg_of(input logic [3:0] d);
		case (d)
			4'd0:    seg_of = 7'h3F;
			4'd1:    seg_of = 7'h06;
			4'd2:    seg_of = 7'h5B;
			4'd3:    seg_of = 7'h4F;
			4'd4:    seg_of = 7'h66;
			4'd5:    seg_of = 7'h6D;
			4'd6:    seg_of = 7'h7D;
			4'd7:    seg_of = 7'h07;
			4'd8:    seg_of = 7'h7F;
			4'd9:    seg_of = 7'h6F;
			default: seg_of = 7'h00;
		endcase
	endfunction

	assign due = tick_due(mux_elapsed_q, cfg.mux_interval);

	// p / 10 as (p * 205) >> 11, exact for 7-bit p
	assign prod10   = 16'(percent) * 16'd205;
	assign q10      = PCT_BITS'(prod10 >> 11);
	assign units    = 4'(percent - PCT_BITS'(q10 * 4'd10));
	assign tens     = (q10 >= PCT_BITS'(10)) ? 4'(q10 - PCT_BITS'(10)) : 4'(q10);
	assign hundreds = (percent >= PCT_BITS'(100)) ? 4'd1 : 4'd0;

	always_comb begin
		case (phase_q)
			PH_TENS: begin
				digit      = tens;
				en_next    = 3'b010;
				phase_next = PH_HUNDREDS;
			end
			PH_HUNDREDS: begin
				digit      = hundreds;
				en_next    = 3'b100;
				phase_next = PH_UNITS;
			end
			default: begin
				digit      = units;
				en_next    = 3'b001;
				phase_next = PH_TENS;
			end
		endcase
	end

	assign seg_raw = seg_of(digit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mux_elapsed_q <= '0;
			phase_q       <= PH_UNITS;
			seg_q         <= '0;
			en_q          <= '0;
		end else if (tick) begin
			mux_elapsed_q <= sat_inc(due ? '0 : mux_elapsed_q);
			if (due) begin
				phase_q <= phase_next;
				en_q    <= en_next;
				seg_q   <= cfg.common_anode ? ~seg_raw : seg_raw;
			end
		end
	end

	assign disp.segments     = seg_q;
	assign disp.digit_enable = en_q;

endmodule

/* tb/sv/tb_motor_soft_reversal_with_percent_display.sv */
// ----------------------------------------------------------------------------
// tb_motor_soft_reversal_with_percent_display
// Self-checking bench for the soft reversal controller and percent display.
// Tick requests go in on a valid/stall channel, and register writes go in on
// a valid/ready channel. A predictor in the bench keeps its own copy of the
// controller state and queues the expected panel state (duties, LEDs,
// segments, digit enables) for every accepted tick. A sink process drains the
// result channel under random stall and compares each result with the oldest
// queued state. Directed tests cover the corner cases. Random traffic then
// runs under several register settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_motor_soft_reversal_with_percent_display;
	import msrpd_pkg::*;

	// A full-scale sample reads as 100 percent.
	localparam int SAMPLE_FULL = (1 << SAMPLE_BITS) - 1;
	// Tick request to result request, through the input and state registers.
	localparam int RESULT_LATENCY = 2;
	// Cycles with no request moving on any channel before the run is given up.
	localparam int WATCHDOG_LIMIT = 1000;
	// Longest idle or stall drawn for one request.
	localparam int MAX_WAIT = 14;

	localparam logic [DIGIT_BITS-1:0] EN_UNITS    = 3'b001;
	localparam logic [DIGIT_BITS-1:0] EN_TENS     = 3'b010;
	localparam logic [DIGIT_BITS-1:0] EN_HUNDREDS = 3'b100;

	typedef enum logic [1:0] {
		PH_UNITS,
		PH_TENS,
		PH_HUNDREDS
	} mux_phase_t;

	// Everything the block shows after one tick.
	typedef struct {
		logic [SAMPLE_BITS-1:0] duty_fwd;
		logic [SAMPLE_BITS-1:0] duty_rev;
		logic                   red;
		logic                   green;
		logic [SEG_BITS-1:0]    seg;
		logic [DIGIT_BITS-1:0]  dig;
	} panel_t;

	logic clk = 1'b0;
	logic arst_n;

	logic                      in_valid;
	logic                      in_stall;
	logic                      left_press;
	logic                      right_press;
	logic                      sample_valid;
	logic [SAMPLE_BITS-1:0]    sample_value;

	logic                      out_valid;
	logic                      out_stall;
	logic [SAMPLE_BITS-1:0]    duty_forward;
	logic [SAMPLE_BITS-1:0]    duty_reverse;
	logic                      red_led;
	logic                      green_led;
	logic [SEG_BITS-1:0]       segments;
	logic [DIGIT_BITS-1:0]     digit_enable;

	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	// Expected panel states, oldest first.
	panel_t panel_states[$];
	int     n_errors = 0;
	int     idle_cycles = 0;
	// Set during a phase that runs both channels without any idle or stall.
	bit     calm = 1'b0;

	// Register copies held by the predictor.
	logic [CFG_DATA_BITS-1:0] cfg_debounce;
	logic [CFG_DATA_BITS-1:0] cfg_ramp_gap;
	logic [SAMPLE_BITS-1:0]   cfg_ramp_dec;
	logic [CFG_DATA_BITS-1:0] cfg_mux_gap;
	logic                     cfg_anode;

	// Controller state held by the predictor.
	tick_cnt_t              since_press;
	tick_cnt_t              since_ramp;
	tick_cnt_t              since_mux;
	logic                   arm_left;
	logic                   arm_right;
	logic                   level_locked;
	logic [SAMPLE_BITS-1:0] held_level;
	logic [SAMPLE_BITS-1:0] last_sample;
	logic [PCT_BITS-1:0]    shown_percent;
	mux_phase_t             mux_phase;
	logic [SAMPLE_BITS-1:0] fwd_duty;
	logic [SAMPLE_BITS-1:0] rev_duty;
	logic                   red_on;
	logic                   green_on;
	logic [SEG_BITS-1:0]    seg_drive;
	logic [DIGIT_BITS-1:0]  digit_drive;

	motor_soft_reversal_with_percent_display u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.left_press   (left_press),
		.right_press  (right_press),
		.sample_valid (sample_valid),
		.sample_value (sample_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.duty_forward (duty_forward),
		.duty_reverse (duty_reverse),
		.red_led      (red_led),
		.green_led    (green_led),
		.segments     (segments),
		.digit_enable (digit_enable),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// Give up when no request has moved on any channel for too long. This
	// also catches an expected result that never shows up.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// Segment pattern of one decimal digit, bit0 is segment a.
	function automatic logic [SEG_BITS-1:0] digit_font(input int d);
		case (d)
			0: return 7'h3F;
			1: return 7'h06;
			2: return 7'h5B;
			3: return 7'h4F;
			4: return 7'h66;
			5: return 7'h6D;
			6: return 7'h7D;
			7: return 7'h07;
			8: return 7'h7F;
			default: return 7'h6F;
		endcase
	endfunction

	// Advance an elapsed-tick counter, holding at all ones.
	function automatic tick_cnt_t count_up(input tick_cnt_t v);
		return (&v) ? v : v + 1'b1;
	endfunction

	// Load the register defaults and clear the controller state.
	task automatic clear_controller();
		cfg_debounce  = DEBOUNCE_RESET;
		cfg_ramp_gap  = RAMP_INTERVAL_RESET;
		cfg_ramp_dec  = RAMP_STEP_RESET;
		cfg_mux_gap   = MUX_INTERVAL_RESET;
		cfg_anode     = 1'b0;
		since_press   = '0;
		since_ramp    = '0;
		since_mux     = '0;
		arm_left      = 1'b0;
		arm_right     = 1'b0;
		level_locked  = 1'b0;
		held_level    = '0;
		last_sample   = '0;
		shown_percent = '0;
		mux_phase     = PH_UNITS;
		fwd_duty      = '0;
		rev_duty      = '0;
		red_on        = 1'b0;
		green_on      = 1'b0;
		seg_drive     = '0;
		digit_drive   = '0;
	endtask

	// Apply one accepted tick to the controller copy and queue the panel
	// state it leads to.
	task automatic advance_controller(input logic lp, input logic rp, input logic sv,
			input logic [SAMPLE_BITS-1:0] val);
		panel_t shown;
		logic   go_left;
		int     digit;

		// Presses share one window: left is tried first and restarts it.
		if (lp && since_press >= cfg_debounce) begin
			arm_left    = 1'b1;
			since_press = '0;
		end
		if (rp && since_press >= cfg_debounce) begin
			arm_right   = 1'b1;
			since_press = '0;
		end

		if (sv) begin
			last_sample   = val;
			shown_percent = PCT_BITS'((int'(val) * 100) / SAMPLE_FULL);
		end

		// Left wins while both are armed; the level is captured only once per
		// reversal, so a takeover keeps it.
		if (arm_left || arm_right) begin
			go_left = arm_left;
			if (!level_locked) begin
				held_level   = last_sample;
				level_locked = 1'b1;
			end
			if (since_ramp >= cfg_ramp_gap) begin
				if (held_level != '0) begin
					held_level = (held_level > cfg_ramp_dec) ? held_level - cfg_ramp_dec : '0;
					if (go_left)
						rev_duty = held_level;
					else
						fwd_duty = held_level;
					since_ramp = '0;
				end else begin
					// Completion leaves the ramp counter running.
					if (go_left) begin
						fwd_duty = last_sample;
						red_on   = 1'b1;
						green_on = 1'b0;
						arm_left = 1'b0;
					end else begin
						rev_duty  = last_sample;
						red_on    = 1'b0;
						green_on  = 1'b1;
						arm_right = 1'b0;
					end
					level_locked = 1'b0;
				end
			end
		end

		if (since_mux >= cfg_mux_gap) begin
			since_mux = '0;
			case (mux_phase)
				PH_TENS: begin
					digit       = (int'(shown_percent) / 10) % 10;
					digit_drive = EN_TENS;
					mux_phase   = PH_HUNDREDS;
				end
				PH_HUNDREDS: begin
					digit       = (int'(shown_percent) / 100) % 10;
					digit_drive = EN_HUNDREDS;
					mux_phase   = PH_UNITS;
				end
				default: begin
					digit       = int'(shown_percent) % 10;
					digit_drive = EN_UNITS;
					mux_phase   = PH_TENS;
				end
			endcase
			seg_drive = digit_font(digit);
			if (cfg_anode)
				seg_drive = ~seg_drive;
		end

		since_press = count_up(since_press);
		since_ramp  = count_up(since_ramp);
		since_mux   = count_up(since_mux);

		shown.duty_fwd = fwd_duty;
		shown.duty_rev = rev_duty;
		shown.red      = red_on;
		shown.green    = green_on;
		shown.seg      = seg_drive;
		shown.dig      = digit_drive;
		panel_states.push_back(shown);
	endtask

	// Send one tick request after a random idle, and predict it once taken.
	// Valid stays high afterwards so that a following tick can go back to back.
	task automatic send_tick(input logic lp, input logic rp, input logic sv,
			input logic [SAMPLE_BITS-1:0] val);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		left_press   <= lp;
		right_press  <= rp;
		sample_valid <= sv;
		sample_value <= val;
		do @(posedge clk); while (in_stall);
		advance_controller(lp, rp, sv, val);
	endtask

	// Drop tick valid and wait until every expected result has arrived.
	task automatic settle();
		in_valid <= 1'b0;
		while (panel_states.size() != 0)
			@(posedge clk);
	endtask

	// Write one register, then mirror it in the predictor with the block's
	// masking. Spare indexes change nothing.
	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_DEBOUNCE:      cfg_debounce = data;
			REG_RAMP_INTERVAL: cfg_ramp_gap = data;
			REG_RAMP_STEP:     cfg_ramp_dec = data[SAMPLE_BITS-1:0];
			REG_MUX_INTERVAL:  cfg_mux_gap  = data;
			REG_COMMON_ANODE:  cfg_anode    = data[0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_settings(input logic [CFG_DATA_BITS-1:0] debounce,
			input logic [CFG_DATA_BITS-1:0] ramp_gap, input logic [CFG_DATA_BITS-1:0] ramp_dec,
			input logic [CFG_DATA_BITS-1:0] mux_gap, input logic [CFG_DATA_BITS-1:0] anode);
		write_reg(REG_DEBOUNCE, debounce);
		write_reg(REG_RAMP_INTERVAL, ramp_gap);
		write_reg(REG_RAMP_STEP, ramp_dec);
		write_reg(REG_MUX_INTERVAL, mux_gap);
		write_reg(REG_COMMON_ANODE, anode);
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_errors++;
		end
	endtask

	// Drain the result channel under random stall and check every result
	// against the oldest expected panel state.
	initial begin : result_sink
		int unsigned hold;
		panel_t      want;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			hold = calm ? 0 : $urandom_range(0, MAX_WAIT);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (out_valid !== 1'b1);
			if (panel_states.size() == 0) begin
				$error("result arrived with no tick waiting for it");
				n_errors++;
			end else begin
				want = panel_states.pop_front();
				check_field("duty_forward", 32'(want.duty_fwd), 32'(duty_forward));
				check_field("duty_reverse", 32'(want.duty_rev), 32'(duty_reverse));
				check_field("red_led", 32'(want.red), 32'(red_led));
				check_field("green_led", 32'(want.green), 32'(green_led));
				check_field("segments", 32'(want.seg), 32'(segments));
				check_field("digit_enable", 32'(want.dig), 32'(digit_enable));
			end
		end
	end

	// Reset register values: presses right after reset fall inside the long
	// window and are dropped.
	task automatic test_reset_defaults();
		settle();
		send_tick(1'b0, 1'b0, 1'b1, '1);
		send_tick(1'b1, 1'b0, 1'b1, '0);
		send_tick(1'b0, 1'b1, 1'b0, 12'h5A5);
	endtask

	// Zero intervals make every event due each tick. A ramp step written
	// with all data bits set keeps only its low bits, a full step.
	task automatic test_left_reversal();
		settle();
		load_settings('0, '0, '1, '0, '0);
		send_tick(1'b1, 1'b0, 1'b1, '1);
		send_tick(1'b0, 1'b0, 1'b0, '0);
		send_tick(1'b0, 1'b0, 1'b0, '0);
	endtask

	// With no debounce window both presses on one tick arm; left runs first
	// and the right reversal follows once it completes.
	task automatic test_both_presses();
		settle();
		send_tick(1'b1, 1'b1, 1'b1, 12'd2048);
		repeat (4) send_tick(1'b0, 1'b0, 1'b0, '0);
	endtask

	// A press inside the window is dropped; a later left press takes over a
	// right reversal and keeps its captured level.
	task automatic test_press_window();
		settle();
		load_settings(20'd3, 20'd1, 20'd1000, 20'd1, '0);
		send_tick(1'b0, 1'b1, 1'b1, 12'd3000);
		send_tick(1'b1, 1'b0, 1'b0, '0);
		send_tick(1'b0, 1'b0, 1'b1, 12'd4000);
		send_tick(1'b1, 1'b0, 1'b0, '0);
	endtask

	// A captured level of zero leaves the opposite channel alone and drives
	// the chosen one at the next due interval.
	task automatic test_zero_level();
		settle();
		load_settings('0, 20'd2, 20'd100, '0, '0);
		send_tick(1'b0, 1'b0, 1'b1, '0);
		send_tick(1'b1, 1'b0, 1'b0, '0);
		repeat (3) send_tick(1'b0, 1'b0, 1'b1, 12'd777);
	endtask

	// Spare register indexes are ignored, a zero step never lets a reversal
	// finish, and common anode flips the segment levels.
	task automatic test_zero_step_anode();
		settle();
		for (int i = int'(REG_COMMON_ANODE) + 1; i < (1 << CFG_INDEX_BITS); i++)
			write_reg(CFG_INDEX_BITS'(i), '1);
		load_settings(20'd1, '0, '0, '0, '1);
		send_tick(1'b0, 1'b1, 1'b1, 12'd1234);
		repeat (3) send_tick(1'b0, 1'b0, 1'b0, '0);
		settle();
		write_reg(REG_COMMON_ANODE, 20'hFFFFE);
		repeat (2) send_tick(1'b0, 1'b0, 1'b1, '1);
	endtask

	// Random ticks under one register setting. Presses come often enough
	// that reversals start, take over and finish, while samples move.
	task automatic run_random_phase(input int n, input logic [CFG_DATA_BITS-1:0] debounce,
			input logic [CFG_DATA_BITS-1:0] ramp_gap, input logic [CFG_DATA_BITS-1:0] ramp_dec,
			input logic [CFG_DATA_BITS-1:0] mux_gap, input logic [CFG_DATA_BITS-1:0] anode,
			input bit no_idle);
		int unsigned            roll;
		logic                   lp;
		logic                   rp;
		logic                   sv;
		logic [SAMPLE_BITS-1:0] val;
		settle();
		load_settings(debounce, ramp_gap, ramp_dec, mux_gap, anode);
		calm = no_idle;
		for (int k = 0; k < n; k++) begin
			roll = $urandom_range(0, 31);
			lp   = (roll < 4) || (roll == 31);
			rp   = (roll >= 4 && roll < 8) || (roll == 31);
			sv   = ($urandom_range(0, 2) == 0);
			case ($urandom_range(0, 7))
				0:       val = '0;
				1:       val = '1;
				default: val = SAMPLE_BITS'($urandom);
			endcase
			send_tick(lp, rp, sv, val);
		end
	endtask

	task automatic test_fast_reversals();
		run_random_phase(180, '0, '0, '1, '0, '0, 1'b0);
	endtask

	task automatic test_soft_ramp_traffic();
		run_random_phase(200, CFG_DATA_BITS'($urandom_range(0, 8)),
			CFG_DATA_BITS'($urandom_range(1, 4)), CFG_DATA_BITS'($urandom_range(300, 1500)),
			CFG_DATA_BITS'($urandom_range(0, 3)), 20'd1, 1'b0);
	endtask

	task automatic test_stuck_ramp_traffic();
		run_random_phase(120, 20'd2, 20'd1, '0, 20'd1, '0, 1'b0);
	endtask

	// Both channels flat out, no idle and no stall.
	task automatic test_back_to_back();
		run_random_phase(200, CFG_DATA_BITS'($urandom_range(0, 4)),
			CFG_DATA_BITS'($urandom_range(0, 2)),
			CFG_DATA_BITS'($urandom_range(0, SAMPLE_FULL)),
			CFG_DATA_BITS'($urandom_range(0, 2)), CFG_DATA_BITS'($urandom), 1'b1);
	endtask

	// Longest intervals: nothing becomes due within the phase.
	task automatic test_extreme_intervals();
		run_random_phase(100, '1, '1, 20'd1, '1, 20'd1, 1'b0);
	endtask

	task automatic test_mixed_traffic();
		run_random_phase(300, CFG_DATA_BITS'($urandom_range(0, 20)),
			CFG_DATA_BITS'($urandom_range(0, 6)),
			CFG_DATA_BITS'($urandom_range(1, SAMPLE_FULL)),
			CFG_DATA_BITS'($urandom_range(0, 5)), CFG_DATA_BITS'($urandom), 1'b0);
	endtask

	initial begin
		// Drive every input to a known level before reset is released.
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		left_press   = 1'b0;
		right_press  = 1'b0;
		sample_valid = 1'b0;
		sample_value = '0;
		cfg_valid    = 1'b0;
		cfg_index    = REG_DEBOUNCE;
		cfg_data     = '0;
		clear_controller();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_left_reversal();
		test_both_presses();
		test_press_window();
		test_zero_level();
		test_zero_step_anode();
		test_fast_reversals();
		test_soft_ramp_traffic();
		test_stuck_ramp_traffic();
		test_back_to_back();
		test_extreme_intervals();
		test_mixed_traffic();

		// Wait out the last results, then let the clock run on so that any
		// stray result still shows up as unexpected.
		calm = 1'b0;
		settle();
		repeat (4 * RESULT_LATENCY) @(posedge clk);
		if (panel_states.size() != 0) begin
			$error("%0d expected results never arrived", panel_states.size());
			n_errors++;
		end
		if (n_errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
